// ----- rtl/core/pcu_pkg.sv -----
// ---------------------------------------------------------------------------
// pcu_pkg
// Shared widths for the Pearson correlation unit.
// ---------------------------------------------------------------------------
package pcu_pkg;
  localparam int SampleBits = 16;
  localparam int MaxCount   = 4096;
  localparam int CountW     = 13;
  localparam int SumW       = 29;
  localparam int SqW        = 43;
  localparam int CrossW     = 44;
  // Variance and numerator terms: n*S2 - S*S, bounded by 2^56.
  localparam int TermW      = 58;
  // Scaled numerator (num * 2^15) and its square.
  localparam int NumW       = 72;
  localparam int SqrW       = 144;
  // Product of the two variance terms.
  localparam int ProdW      = 116;
  localparam int QW         = 16;
endpackage

// ----- rtl/core/pcu_serial_mul.sv -----
// ---------------------------------------------------------------------------
// pcu_serial_mul
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module pcu_serial_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pcu_pkg::SqrW-1:0]  op_a,
  input  logic [pcu_pkg::NumW-1:0]  op_b,
  input  logic [7:0]                nbits,
  output logic                      done,
  output logic [pcu_pkg::SqrW-1:0]  prod
);
  import pcu_pkg::*;

  logic [SqrW-1:0] mcand;
  logic [NumW-1:0] mplier;
  logic [7:0]      left;
  logic            run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      run    <= 1'b1;
      done   <= 1'b0;
      mcand  <= op_a;
      mplier <= op_b;
      left   <= nbits;
      prod   <= '0;
    end else if (run) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      left   <= left - 8'd1;
      done   <= (left == 8'd1);
      if (left == 8'd1) run <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end
endmodule

// ----- rtl/core/pearson_correlation_unit.sv -----
// ---------------------------------------------------------------------------
// pearson_correlation_unit
// Streaming Pearson correlation of paired samples, result in Q1.15.
// ---------------------------------------------------------------------------
// Pairs enter one per cycle while a set is accumulating; a registered stage
// forms the two squares and the cross product of each pair before the sums
// are updated. On the pair marked tlast the block stops taking words and
// evaluates the coefficient with a single shared bit-serial multiplier. Eight
// products build the variance terms, the numerator, its square and the
// product of the variances. Then sixteen trial steps pick the result bits
// from the top down, each costing one multiply by a 32-bit trial square.
// The result word waits in an output register; the next set is accepted
// once it has been taken. A coefficient of exactly +1 reads as 32767. Sets
// of one pair, sets in which either series sums to zero and sets with a
// constant series report zero. Pairs past 4096 are dropped and flag overflow.
module pearson_correlation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_a [15:0], sample_b [31:16]
  input  logic        s_tlast,   // last_pair
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // correlation [15:0], pair_count [28:16], overflow [29]
  output logic        m_tlast
);
  import pcu_pkg::*;

  localparam logic [3:0] S_ACC = 4'd0, S_VA0 = 4'd1, S_VA1 = 4'd2, S_VB0 = 4'd3,
                         S_VB1 = 4'd4, S_NU0 = 4'd5, S_NU1 = 4'd6, S_SQ = 4'd7,
                         S_PR = 4'd8, S_TRY = 4'd9, S_OUT = 4'd10, S_EVAL = 4'd11;

  logic [3:0] state;
  logic signed [SampleBits-1:0] a_in, b_in;
  logic [CountW-1:0] count;
  logic signed [SumW-1:0] sa, sb;
  logic [SqW-1:0] saa, sbb;
  logic signed [CrossW-1:0] sab;
  logic dropped;
  logic accept;

  // Product stage so the accumulators see registered products.
  logic p_v, p_last;
  logic signed [SampleBits-1:0] pa, pb;
  logic signed [31:0] paa, pbb, pab;

  assign s_tready = (state == S_ACC) && !p_last;
  assign accept   = s_tvalid && s_tready;
  assign a_in     = s_tdata[15:0];
  assign b_in     = s_tdata[31:16];

  // Serial multiplier and operand mux.
  logic            m_start, m_done;
  logic [SqrW-1:0] m_a, m_p;
  logic [NumW-1:0] m_b;
  logic [7:0]      m_n;
  pcu_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(m_start), .op_a(m_a), .op_b(m_b),
    .nbits(m_n), .done(m_done), .prod(m_p)
  );

  logic [TermW-1:0] mag_s;         // |sum| scratch
  logic [TermW-1:0] va, vb, tmp;
  logic             neg, zero_res;
  logic [SqrW-1:0]  x2;
  logic [ProdW-1:0] yv;
  logic [QW-1:0]    q;
  logic [4:0]       bitn;
  logic [QW-1:0]    trial;
  logic [CountW-1:0] out_cnt;
  logic             out_ovf;
  logic [QW-1:0]    out_r;

  assign trial = q | (QW'(1) << bitn[3:0]);

  function automatic logic [TermW-1:0] absv(input logic signed [TermW-1:0] v);
    absv = v[TermW-1] ? TermW'(-v) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_ACC;
      p_v      <= 1'b0;
      p_last   <= 1'b0;
      count    <= '0;
      sa       <= '0;
      sb       <= '0;
      saa      <= '0;
      sbb      <= '0;
      sab      <= '0;
      dropped  <= 1'b0;
      m_tvalid <= 1'b0;
      m_start  <= 1'b0;
    end else begin
      // The start pulse lasts one cycle; no state raises it while it is high.
      if (m_start) m_start <= 1'b0;
      p_v     <= accept;
      if (accept) begin
        pa     <= a_in;
        pb     <= b_in;
        paa    <= a_in * a_in;
        pbb    <= b_in * b_in;
        pab    <= a_in * b_in;
        p_last <= s_tlast;
      end
      if (p_v) begin
        if (count < CountW'(MaxCount)) begin
          count <= count + 1'b1;
          sa    <= sa + SumW'(pa);
          sb    <= sb + SumW'(pb);
          saa   <= saa + SqW'(unsigned'(paa));
          sbb   <= sbb + SqW'(unsigned'(pbb));
          sab   <= sab + CrossW'(pab);
        end else begin
          dropped <= 1'b1;
        end
        if (p_last) state <= S_EVAL;
      end
      case (state)
        S_ACC: ;
        S_EVAL: begin
          p_last   <= 1'b0;
          out_cnt  <= count;
          out_ovf  <= dropped;
          zero_res <= (count <= CountW'(1)) || (sa == '0) || (sb == '0);
          // n * Saa
          m_a <= SqrW'(saa); m_b <= NumW'(count); m_n <= 8'd13;
          m_start <= 1'b1;
          state <= S_VA0;
        end
        S_VA0: if (m_done) begin
          tmp   <= TermW'(m_p);
          mag_s <= absv(TermW'(sa));
          m_a <= SqrW'(absv(TermW'(sa))); m_b <= NumW'(absv(TermW'(sa)));
          m_n <= 8'd29; m_start <= 1'b1;
          state <= S_VA1;
        end
        S_VA1: if (m_done) begin
          va  <= tmp - TermW'(m_p);
          m_a <= SqrW'(sbb); m_b <= NumW'(count); m_n <= 8'd13;
          m_start <= 1'b1;
          state <= S_VB0;
        end
        S_VB0: if (m_done) begin
          tmp <= TermW'(m_p);
          m_a <= SqrW'(absv(TermW'(sb))); m_b <= NumW'(absv(TermW'(sb)));
          m_n <= 8'd29; m_start <= 1'b1;
          state <= S_VB1;
        end
        S_VB1: if (m_done) begin
          vb  <= tmp - TermW'(m_p);
          // n * Sab, signed via magnitude
          m_a <= SqrW'(absv(TermW'(sab))); m_b <= NumW'(count); m_n <= 8'd13;
          m_start <= 1'b1;
          state <= S_NU0;
        end
        S_NU0: if (m_done) begin
          tmp <= sab[CrossW-1] ? TermW'(-m_p[TermW-1:0]) : TermW'(m_p);
          m_a <= SqrW'(mag_s); m_b <= NumW'(absv(TermW'(sb)));
          m_n <= 8'd29; m_start <= 1'b1;
          state <= S_NU1;
        end
        S_NU1: if (m_done) begin
          // numerator = n*Sab - Sa*Sb, then magnitude scaled by 2^15
          if ((sa[SumW-1] ^ sb[SumW-1])) begin
            neg <= tmp[TermW-1] ^ 1'b0 ?
                   ((tmp + TermW'(m_p)) >> (TermW-1)) != '0 :
                   ((tmp + TermW'(m_p)) >> (TermW-1)) != '0;
            m_a <= SqrW'(absv(tmp + TermW'(m_p))) << 15;
            m_b <= NumW'(absv(tmp + TermW'(m_p))) << 15;
          end else begin
            neg <= ((tmp - TermW'(m_p)) >> (TermW-1)) != '0;
            m_a <= SqrW'(absv(tmp - TermW'(m_p))) << 15;
            m_b <= NumW'(absv(tmp - TermW'(m_p))) << 15;
          end
          if (va == '0 || vb == '0) zero_res <= 1'b1;
          m_n <= 8'd72; m_start <= 1'b1;
          state <= S_SQ;
        end
        S_SQ: if (m_done) begin
          x2  <= m_p;
          m_a <= SqrW'(va); m_b <= NumW'(vb); m_n <= 8'd58; m_start <= 1'b1;
          state <= S_PR;
        end
        S_PR: if (m_done) begin
          yv   <= ProdW'(m_p);
          q    <= '0;
          bitn <= 5'd15;
          m_a  <= SqrW'(m_p);
          state <= S_TRY;
          // first trial: (2^15)^2 * y
          m_b  <= NumW'(32'h4000_0000);
          m_n  <= 8'd32; m_start <= 1'b1;
        end
        S_TRY: if (m_done) begin
          logic [QW-1:0] qn;
          logic [QW-1:0] nt;
          qn = (m_p <= x2) ? trial : q;
          nt = qn | (QW'(1) << (bitn[3:0] - 4'd1));
          q <= qn;
          if (bitn == 5'd0) begin
            // Only a coefficient of magnitude exactly 1 reaches the top bit.
            out_r <= zero_res ? '0 :
                     neg ? QW'(-qn) :
                     qn[QW-1] ? QW'(16'h7FFF) : qn;
            m_tvalid <= 1'b1;
            state <= S_OUT;
          end else begin
            bitn <= bitn - 5'd1;
            m_a  <= SqrW'(yv);
            m_b  <= NumW'(32'(nt) * 32'(nt));
            m_n  <= 8'd32; m_start <= 1'b1;
          end
        end
        S_OUT: if (m_tready) begin
          m_tvalid <= 1'b0;
          count <= '0; sa <= '0; sb <= '0; saa <= '0; sbb <= '0; sab <= '0;
          dropped <= 1'b0;
          state <= S_ACC;
        end
        default: state <= S_ACC;
      endcase
    end
  end

  assign m_tdata = {2'b00, out_ovf, out_cnt, out_r};
  assign m_tlast = 1'b1;

  // The counter never passes its capacity.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MaxCount)) else $error("count above capacity");
  // No words are taken while a result is pending.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while result pending");
  // A result never outlives its handshake.
  a_drop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> !m_tvalid) else $error("result repeated");
endmodule
